FILE: rtl/cbem_pkg.sv
// ----------------------------------------------------------------------------
// cbem_pkg: shared types and constants of the chunked byte entropy meter
// Histogram geometry, result codes, field widths and the state machine types.
// ----------------------------------------------------------------------------
package cbem_pkg;

	localparam int HIST_BINS    = 256;
	localparam int BIN_BITS     = 8;
	localparam int ENTROPY_BITS = 20;
	localparam int INDEX_BITS   = 16;
	localparam int LEN_BITS     = 32;
	localparam int NORM_BITS    = 64;
	localparam int EXP_BITS     = 6;
	localparam int MANT_BITS    = 32;

	localparam logic [LEN_BITS-1:0]   LEN_RESET = 32'd65536;
	localparam logic [INDEX_BITS-1:0] INDEX_MAX = 16'hFFFF;

	localparam logic RESULT_CHUNK  = 1'b0;
	localparam logic RESULT_STREAM = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD,
		ST_CLOSE_START,
		ST_CLOSE_WAIT,
		ST_CLOSE_EMIT,
		ST_PART_START,
		ST_PART_WAIT,
		ST_PART_EMIT,
		ST_STRM_START,
		ST_STRM_WAIT,
		ST_STRM_EMIT
	} top_state_t;

	typedef enum logic [3:0] {
		E_IDLE,
		E_LNT,
		E_RD,
		E_DATA,
		E_LNC,
		E_MUL,
		E_ACC,
		E_NEXT,
		E_DIV,
		E_DONE
	} eval_state_t;

	typedef enum logic [1:0] {
		L_IDLE,
		L_NORM,
		L_SQR,
		L_DONE
	} log_state_t;

	typedef struct packed {
		logic                    done;
		logic [ENTROPY_BITS-1:0] value;
	} eval_status_t;

endpackage

FILE: rtl/cbem_if.sv
// ----------------------------------------------------------------------------
// cbem interfaces: byte input, result output and configuration channels
// Each channel carries valid, ready and its payload.
// ----------------------------------------------------------------------------
interface cbem_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_data;
	modport source (output valid, output data_byte, output end_of_data, input ready);
	modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface cbem_result_if;
	logic        valid;
	logic        ready;
	logic [19:0] entropy_value;
	logic        result_kind;
	logic [15:0] chunk_id;
	logic        last_result;
	modport source (output valid, output entropy_value, output result_kind,
		output chunk_id, output last_result, input ready);
	modport sink   (input valid, input entropy_value, input result_kind,
		input chunk_id, input last_result, output ready);
endinterface

interface cbem_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/cbem_ram.sv
// ----------------------------------------------------------------------------
// cbem_ram: generic single-write, single-read synchronous RAM
// Read data is registered, available in the cycle after the address.
// ----------------------------------------------------------------------------
module cbem_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/cbem_log2.sv
// ----------------------------------------------------------------------------
// cbem_log2: iterative fixed point log2
// Normalizes the operand, then squares the mantissa once per fraction bit.
// ----------------------------------------------------------------------------
module cbem_log2 import cbem_pkg::*; #(
	parameter int IN_BITS       = 48,
	parameter int FRACTION_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [IN_BITS-1:0]                x,
	output logic                              done,
	output logic [EXP_BITS+FRACTION_BITS-1:0] value
);

	localparam int CW = $clog2(FRACTION_BITS + 1);

	log_state_t state_q, state_d;

	logic [NORM_BITS-1:0]     xn_q;
	logic [EXP_BITS-1:0]      e_q;
	logic [MANT_BITS-1:0]     m_q;
	logic [FRACTION_BITS-1:0] frac_q;
	logic [CW-1:0]            cnt_q;
	logic [2*MANT_BITS-1:0]   sq;
	logic [MANT_BITS:0]       t;

	assign sq = m_q * m_q;
	assign t  = sq[2*MANT_BITS-1:MANT_BITS-1];

	always_comb begin
		state_d = state_q;
		case (state_q)
			L_IDLE: if (start) state_d = L_NORM;
			L_NORM: if (xn_q[NORM_BITS-1]) state_d = L_SQR;
			L_SQR:  if (cnt_q == CW'(1)) state_d = L_DONE;
			L_DONE: state_d = L_IDLE;
			default: state_d = L_IDLE;
		endcase
	end

	always_comb begin
		done  = 1'b0;
		value = {e_q, frac_q};
		case (state_q)
			L_DONE:  done = 1'b1;
			default: done = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				xn_q <= NORM_BITS'(x);
				e_q  <= EXP_BITS'(NORM_BITS - 1);
			end
			L_NORM: begin
				if (xn_q[NORM_BITS-1]) begin
					m_q   <= xn_q[NORM_BITS-1 -: MANT_BITS];
					cnt_q <= CW'(FRACTION_BITS);
				end else if (xn_q[NORM_BITS-1 -: 8] == 8'd0) begin
					xn_q <= xn_q << 8;
					e_q  <= e_q - EXP_BITS'(8);
				end else begin
					xn_q <= xn_q << 1;
					e_q  <= e_q - EXP_BITS'(1);
				end
			end
			L_SQR: begin
				// square, keep 32 significant bits, peel off one fraction bit
				if (t[MANT_BITS]) begin
					m_q    <= t[MANT_BITS:1];
					frac_q <= {frac_q[FRACTION_BITS-2:0], 1'b1};
				end else begin
					m_q    <= t[MANT_BITS-1:0];
					frac_q <= {frac_q[FRACTION_BITS-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CW'(1);
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/cbem_eval.sv
// ----------------------------------------------------------------------------
// cbem_eval: histogram entropy evaluator
// Sweeps the 256 bins unless N is 0, sums c*(L(N)-L(c)) exactly, divides by N bit-serially.
// ----------------------------------------------------------------------------
module cbem_eval import cbem_pkg::*; #(
	parameter int CNT_BITS      = 48,
	parameter int FRACTION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [CNT_BITS-1:0] total,
	input  logic [CNT_BITS-1:0] rd_data,
	output logic [BIN_BITS-1:0] rd_addr,
	output logic                sweep_we,
	output eval_status_t        status
);

	localparam int LW = EXP_BITS + FRACTION_BITS;
	localparam int AW = 2 * MANT_BITS + LW + BIN_BITS;
	localparam int DW = $clog2(AW);
	localparam logic [AW-1:0] LIMIT = AW'(8) << FRACTION_BITS;

	eval_state_t state_q, state_d;

	logic [CNT_BITS-1:0]    tot_q;
	logic [LW-1:0]          ln_q;
	logic [LW-1:0]          d_q;
	logic [BIN_BITS-1:0]    bin_q;
	logic [CNT_BITS-1:0]    c_q;
	logic [2*MANT_BITS-1:0] c_pad;
	logic                   piece_q;
	logic [MANT_BITS+LW-1:0] prod_q;
	logic [AW-1:0]          acc_q;
	logic [AW-1:0]          q_q;
	logic [CNT_BITS-1:0]    r_q;
	logic [CNT_BITS:0]      rn;
	logic                   take;
	logic [DW-1:0]          cnt_q;

	logic                   log_start;
	logic [CNT_BITS-1:0]    log_x;
	logic                   log_done;
	logic [LW-1:0]          log_val;

	cbem_log2 #(
		.IN_BITS       (CNT_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.x      (log_x),
		.done   (log_done),
		.value  (log_val)
	);

	assign c_pad   = (2*MANT_BITS)'(c_q);
	assign rd_addr = bin_q;
	// the bin just read is consumed, so it may be zeroed behind the sweep
	assign sweep_we = (state_q == E_DATA);
	assign rn      = {r_q, acc_q[AW-1]};
	assign take    = (rn >= {1'b0, tot_q});

	always_comb begin
		state_d = state_q;
		case (state_q)
			E_IDLE: if (start) state_d = (total == '0) ? E_DONE : E_LNT;
			E_LNT:  if (log_done) state_d = E_RD;
			E_RD:   state_d = E_DATA;
			E_DATA: state_d = (rd_data == '0) ? E_NEXT : E_LNC;
			E_LNC:  if (log_done) state_d = E_MUL;
			E_MUL:  state_d = E_ACC;
			E_ACC:  state_d = piece_q ? E_NEXT : E_MUL;
			E_NEXT: state_d = (bin_q == BIN_BITS'(HIST_BINS - 1)) ? E_DIV : E_RD;
			E_DIV:  if (cnt_q == '0) state_d = E_DONE;
			E_DONE: state_d = E_IDLE;
			default: state_d = E_IDLE;
		endcase
	end

	always_comb begin
		log_start    = 1'b0;
		log_x        = rd_data;
		status.done  = 1'b0;
		status.value = (q_q > LIMIT) ? LIMIT[ENTROPY_BITS-1:0] : q_q[ENTROPY_BITS-1:0];
		case (state_q)
			E_IDLE: begin
				log_start = start && (total != '0);
				log_x     = total;
			end
			E_DATA:  log_start = (rd_data != '0);
			E_DONE:  status.done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			E_IDLE: begin
				tot_q <= total;
				acc_q <= '0;
				q_q   <= '0;
				r_q   <= '0;
				bin_q <= '0;
				cnt_q <= DW'(AW - 1);
			end
			E_LNT: if (log_done) ln_q <= log_val;
			E_DATA: c_q <= rd_data;
			E_LNC: begin
				if (log_done) begin
					d_q     <= (log_val > ln_q) ? '0 : ln_q - log_val;
					piece_q <= 1'b0;
				end
			end
			E_MUL: prod_q <= (piece_q ? c_pad[2*MANT_BITS-1:MANT_BITS]
				: c_pad[MANT_BITS-1:0]) * d_q;
			E_ACC: begin
				acc_q   <= acc_q + (AW'(prod_q) << (piece_q ? MANT_BITS : 0));
				piece_q <= 1'b1;
			end
			E_NEXT: bin_q <= bin_q + BIN_BITS'(1);
			E_DIV: begin
				// restoring division, one quotient bit per cycle
				acc_q <= acc_q << 1;
				r_q   <= take ? CNT_BITS'(rn - {1'b0, tot_q}) : rn[CNT_BITS-1:0];
				q_q   <= {q_q[AW-2:0], take};
				cnt_q <= cnt_q - DW'(1);
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/chunked_byte_entropy_meter.sv
// ----------------------------------------------------------------------------
// chunked_byte_entropy_meter: per-chunk and whole-stream byte entropy
// Counts bytes in chunk and stream histograms held in RAM, emits Q4.16 entropy.
// ----------------------------------------------------------------------------
//  channel  | dir | beat
//  bytes    | in  | data_byte, end_of_data
//  results  | out | entropy_value, result_kind, chunk_id, last_result
//  cfg      | in  | data = chunk_length
//
// Each byte is read from the histograms at accept, then incremented and written
// back; no byte is accepted during the write back. An evaluation takes the log
// of the total, then a log and a two-part multiply-accumulate per used bin, then
// the division; bytes are held off meanwhile. Reset starts a pass over all 256
// bins zeroing both histograms; each sweep zeroes the bins it reads. One result
// register: a stalled result holds off the next.
module chunked_byte_entropy_meter import cbem_pkg::*; #(
	parameter int CHUNK_COUNT_BITS  = 32,
	parameter int STREAM_COUNT_BITS = 48,
	parameter int FRACTION_BITS     = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	cbem_byte_if.sink     bytes,
	cbem_result_if.source results,
	cbem_cfg_if.sink      cfg
);

	localparam int CB   = CHUNK_COUNT_BITS;
	localparam int SB   = STREAM_COUNT_BITS;
	localparam int W    = (CB > SB) ? CB : SB;
	localparam int CMPW = (CB > LEN_BITS) ? CB : LEN_BITS;

	top_state_t state_q, state_d;

	logic [LEN_BITS-1:0]   len_q;
	logic [CB-1:0]         ccnt_q;
	logic [SB-1:0]         scnt_q;
	logic [INDEX_BITS-1:0] cidx_q;
	logic [BIN_BITS-1:0]   byte_q;
	logic                  end_q;
	logic [BIN_BITS-1:0]   clr_q;
	logic [ENTROPY_BITS-1:0] ent_q;

	logic                    out_valid_q;
	logic [ENTROPY_BITS-1:0] out_ent_q;
	logic                    out_kind_q;
	logic [INDEX_BITS-1:0]   out_num_q;
	logic                    out_last_q;
	logic                    out_free;
	logic                    emit;

	logic [BIN_BITS-1:0] raddr;
	logic [BIN_BITS-1:0] waddr;
	logic [CB-1:0]       crd;
	logic [SB-1:0]       srd;
	logic [CB-1:0]       cwdata;
	logic [SB-1:0]       swdata;
	logic                cwe;
	logic                swe;
	logic [CB-1:0]       ccnt_next;
	logic                close;
	logic                s_room;

	logic                eval_start;
	logic                eval_stream;
	logic [W-1:0]        eval_total;
	logic [W-1:0]        eval_data;
	logic [BIN_BITS-1:0] eval_addr;
	logic                eval_clr;
	eval_status_t        eval_st;

	cbem_ram #(.WIDTH(CB), .DEPTH(HIST_BINS)) u_chunk_ram (
		.clk   (clk),
		.we    (cwe),
		.waddr (waddr),
		.wdata (cwdata),
		.raddr (raddr),
		.rdata (crd)
	);

	cbem_ram #(.WIDTH(SB), .DEPTH(HIST_BINS)) u_stream_ram (
		.clk   (clk),
		.we    (swe),
		.waddr (waddr),
		.wdata (swdata),
		.raddr (raddr),
		.rdata (srd)
	);

	cbem_eval #(
		.CNT_BITS      (W),
		.FRACTION_BITS (FRACTION_BITS)
	) u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (eval_start),
		.total    (eval_total),
		.rd_data  (eval_data),
		.rd_addr  (eval_addr),
		.sweep_we (eval_clr),
		.status   (eval_st)
	);

	assign ccnt_next = ccnt_q + CB'(1);
	assign close     = (CMPW'(ccnt_next) >= CMPW'(len_q)) || (ccnt_next == '1);
	assign s_room    = (scnt_q != '1);
	assign out_free  = !out_valid_q || results.ready;
	assign emit      = out_free && (state_q == ST_CLOSE_EMIT || state_q == ST_PART_EMIT
		|| state_q == ST_STRM_EMIT);
	assign raddr     = (state_q == ST_IDLE) ? bytes.data_byte : eval_addr;
	assign eval_data = eval_stream ? W'(srd) : W'(crd);

	assign cfg.ready             = 1'b1;
	assign results.valid         = out_valid_q;
	assign results.entropy_value = out_ent_q;
	assign results.result_kind   = out_kind_q;
	assign results.chunk_id      = out_num_q;
	assign results.last_result   = out_last_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:       if (clr_q == BIN_BITS'(HIST_BINS - 1)) state_d = ST_IDLE;
			ST_IDLE:        if (bytes.valid) state_d = ST_UPD;
			ST_UPD:         state_d = close ? ST_CLOSE_START
				: (end_q ? ST_PART_START : ST_IDLE);
			ST_CLOSE_START: state_d = ST_CLOSE_WAIT;
			ST_CLOSE_WAIT:  if (eval_st.done) state_d = ST_CLOSE_EMIT;
			ST_CLOSE_EMIT:  if (out_free) state_d = end_q ? ST_PART_START : ST_IDLE;
			ST_PART_START:  state_d = ST_PART_WAIT;
			ST_PART_WAIT:   if (eval_st.done) state_d = ST_PART_EMIT;
			ST_PART_EMIT:   if (out_free) state_d = ST_STRM_START;
			ST_STRM_START:  state_d = ST_STRM_WAIT;
			ST_STRM_WAIT:   if (eval_st.done) state_d = ST_STRM_EMIT;
			ST_STRM_EMIT:   if (out_free) state_d = ST_IDLE;
			default:        state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		bytes.ready = 1'b0;
		cwe         = 1'b0;
		swe         = 1'b0;
		waddr       = byte_q;
		cwdata      = crd + CB'(1);
		swdata      = srd + SB'(1);
		eval_start  = 1'b0;
		eval_stream = 1'b0;
		eval_total  = W'(ccnt_q);
		case (state_q)
			ST_CLEAR: begin
				cwe    = 1'b1;
				swe    = 1'b1;
				waddr  = clr_q;
				cwdata = '0;
				swdata = '0;
			end
			ST_IDLE: bytes.ready = 1'b1;
			ST_UPD: begin
				cwe = 1'b1;
				swe = s_room;
			end
			ST_CLOSE_START, ST_PART_START: eval_start = 1'b1;
			ST_CLOSE_WAIT, ST_PART_WAIT: begin
				cwe    = eval_clr;
				waddr  = eval_addr;
				cwdata = '0;
			end
			ST_STRM_START: begin
				eval_start  = 1'b1;
				eval_stream = 1'b1;
				eval_total  = W'(scnt_q);
			end
			ST_STRM_WAIT: begin
				eval_stream = 1'b1;
				eval_total  = W'(scnt_q);
				swe         = eval_clr;
				waddr       = eval_addr;
				swdata      = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			len_q       <= LEN_RESET;
			ccnt_q      <= '0;
			scnt_q      <= '0;
			cidx_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				len_q <= cfg.data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + BIN_BITS'(1);
				ST_UPD: begin
					ccnt_q <= ccnt_next;
					if (s_room) begin
						scnt_q <= scnt_q + SB'(1);
					end
				end
				ST_CLOSE_EMIT: begin
					if (out_free) begin
						ccnt_q <= '0;
						if (cidx_q != INDEX_MAX) begin
							cidx_q <= cidx_q + INDEX_BITS'(1);
						end
					end
				end
				ST_STRM_EMIT: begin
					if (out_free) begin
						ccnt_q <= '0;
						scnt_q <= '0;
						cidx_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_q <= bytes.data_byte;
			end_q  <= bytes.end_of_data;
		end
		if (eval_st.done) begin
			ent_q <= eval_st.value;
		end
		if (emit) begin
			case (state_q)
				ST_CLOSE_EMIT, ST_PART_EMIT: begin
					out_ent_q  <= ent_q;
					out_kind_q <= RESULT_CHUNK;
					out_num_q  <= cidx_q;
					out_last_q <= 1'b0;
				end
				ST_STRM_EMIT: begin
					out_ent_q  <= ent_q;
					out_kind_q <= RESULT_STREAM;
					out_num_q  <= '0;
					out_last_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLOSE_EMIT && out_free) |=> (ccnt_q == '0))
		else $error("chunk count not cleared after chunk result");

	a_stream_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == RESULT_STREAM) |-> out_last_q)
		else $error("stream result not marked last");

	a_no_write_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLOSE_WAIT || state_q == ST_PART_WAIT
			|| state_q == ST_STRM_WAIT)
		|-> ((!cwe || cwdata == '0) && (!swe || swdata == '0)))
		else $error("histogram count written during evaluation");

	a_emit_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STRM_EMIT) |-> $past(state_q == ST_STRM_WAIT
			|| state_q == ST_STRM_EMIT))
		else $error("stream result without evaluation");

endmodule
